// ----- rtl/core/percent_codec_defines.svh -----
// ----------------------------------------------------------------------------
// Percent codec assertion macros
// Shared property wrappers for the codec checkers; clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef PERCENT_CODEC_DEFINES_SVH
`define PERCENT_CODEC_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define PCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define PCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pct_pkg.sv -----
// ----------------------------------------------------------------------------
// Percent codec package
// Mode codes, character constants and the character class helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pct_pkg;

  typedef enum logic [1:0] {
    MODE_DECODE        = 2'd0,
    MODE_ENC_GENERAL   = 2'd1,
    MODE_ENC_COMPONENT = 2'd2,
    MODE_ENC_URI       = 2'd3
  } mode_t;

  localparam logic [7:0] PCT_CHAR    = 8'h25;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;

  // Bit 4 flags a hex digit of either case, bits 3:0 carry its value
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

  function automatic logic is_safe(input logic [7:0] b, input mode_t m);
    logic ok;
    ok = 1'b0;
    if (b < ASCII_LIMIT) begin
      if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
          (b >= 8'h61 && b <= 8'h7A)) begin
        ok = 1'b1;
      end
      if (b == 8'h2D || b == 8'h2E || b == 8'h5F || b == 8'h7E) begin
        ok = 1'b1;
      end
      if ((m == MODE_ENC_COMPONENT || m == MODE_ENC_URI) &&
          (b == 8'h21 || b == 8'h27 || b == 8'h28 || b == 8'h29 || b == 8'h2A)) begin
        ok = 1'b1;
      end
      if (m == MODE_ENC_URI &&
          (b == 8'h23 || b == 8'h24 || b == 8'h26 || b == 8'h2B || b == 8'h2C ||
           b == 8'h2F || b == 8'h3A || b == 8'h3B || b == 8'h3D || b == 8'h3F ||
           b == 8'h40)) begin
        ok = 1'b1;
      end
    end
    return ok;
  endfunction

endpackage

// ----- rtl/core/pct_in_if.sv -----
// ----------------------------------------------------------------------------
// Percent codec input channel
// One raw byte per word with an end-of-string mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       string_end;

  modport source (output valid, output data_byte, output string_end, input ready);
  modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

// ----- rtl/core/pct_out_if.sv -----
// ----------------------------------------------------------------------------
// Percent codec result channel
// One result byte per word with run and string markers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  modport source (output valid, output out_byte, output run_last, output string_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_done,
                  output ready);
endinterface

// ----- rtl/core/pct_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Percent codec configuration channel
// Write channel for the mode register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pct_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;

  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

// ----- rtl/core/percent_codec.sv -----
// Result: registered, first byte in the cycle after the input word is taken.
// Throughput: one input word per cycle while the result side is ready and
//   each byte yields at most one result; an encoded escape yields three
//   result bytes, one per cycle unless the result side stalls, and the
//   three-entry result register holds off input until its last byte goes.
// Reset: synchronous, active high; mode to decode, escape state and result register cleared.
// ----------------------------------------------------------------------------
// Percent codec
// Streaming percent encoder and decoder with a three-byte result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module percent_codec (
  input  logic         clk,
  input  logic         rst,
  pct_cfg_if.sink      cfg,
  pct_in_if.sink       item,
  pct_out_if.source    result
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  pct_pkg::mode_t mode;
  phase_t         phase;
  phase_t         phase_next;
  logic [7:0]     held_digit;
  logic [7:0]     held_digit_next;

  logic [7:0]     res_buf [0:2];
  logic [1:0]     res_cnt;
  logic           res_end;

  logic [7:0]     b;
  logic           lst;
  logic [4:0]     b_hex;
  logic [4:0]     held_hex;
  logic [1:0]     n;
  logic [7:0]     r0;
  logic [7:0]     r1;
  logic [7:0]     r2;
  logic           take;
  logic           accept;

  assign b        = item.data_byte;
  assign lst      = item.string_end;
  assign b_hex    = pct_pkg::hex_val(b);
  assign held_hex = pct_pkg::hex_val(held_digit);

  assign take       = result.valid && result.ready;
  assign item.ready = (res_cnt == 2'd0) || (take && res_cnt == 2'd1);
  assign accept     = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  assign result.valid       = (res_cnt != 2'd0);
  assign result.out_byte    = res_buf[0];
  assign result.run_last    = (res_cnt == 2'd1);
  assign result.string_done = (res_cnt == 2'd1) && res_end;

  always_comb begin
    n               = 2'd0;
    r0              = b;
    r1              = b;
    r2              = b;
    phase_next      = PH_IDLE;
    held_digit_next = held_digit;
    if (mode != pct_pkg::MODE_DECODE) begin
      if (pct_pkg::is_safe(b, mode)) begin
        n = 2'd1;
      end else begin
        n  = 2'd3;
        r0 = pct_pkg::PCT_CHAR;
        r1 = pct_pkg::hex_char(b[7:4]);
        r2 = pct_pkg::hex_char(4'(b & pct_pkg::NIBBLE_MASK));
      end
    end else begin
      case (phase)
        PH_PCT: begin
          if (lst) begin
            n  = 2'd2;
            r0 = pct_pkg::PCT_CHAR;
            r1 = b;
          end else if (b_hex[4]) begin
            held_digit_next = b;
            phase_next      = PH_DIGIT;
          end else if (b == pct_pkg::PCT_CHAR) begin
            // drop the earlier escape, start a fresh one
            phase_next = PH_PCT;
          end else begin
            n = 2'd1;
          end
        end
        PH_DIGIT: begin
          if (b_hex[4]) begin
            n  = 2'd1;
            r0 = {held_hex[3:0], b_hex[3:0]};
          end else begin
            // release the held digit, then treat this byte as plain
            r0 = held_digit;
            r1 = b;
            if (b == pct_pkg::PCT_CHAR && !lst) begin
              n          = 2'd1;
              phase_next = PH_PCT;
            end else begin
              n = 2'd2;
            end
          end
        end
        default: begin
          if (b == pct_pkg::PCT_CHAR && !lst) begin
            phase_next = PH_PCT;
          end else begin
            n = 2'd1;
          end
        end
      endcase
      if (lst) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= pct_pkg::MODE_DECODE;
      phase      <= PH_IDLE;
      held_digit <= 8'd0;
      res_cnt    <= 2'd0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        mode <= pct_pkg::mode_t'(cfg.mode);
      end
      if (accept) begin
        phase      <= phase_next;
        held_digit <= held_digit_next;
      end
      if (accept && n != 2'd0) begin
        res_buf[0] <= r0;
        res_buf[1] <= r1;
        res_buf[2] <= r2;
        res_cnt    <= n;
        res_end    <= lst;
      end else if (take) begin
        // advance the result register by one byte
        res_buf[0] <= res_buf[1];
        res_buf[1] <= res_buf[2];
        res_cnt    <= res_cnt - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/pct_checker.sv -----
// ----------------------------------------------------------------------------
// Percent codec checker
// Port-level properties of the codec, bound into the codec module.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "percent_codec_defines.svh"

module pct_checker (
  input  logic         clk,
  input  logic         rst,
  pct_cfg_if.sink      cfg,
  pct_in_if.sink       item,
  pct_out_if.source    result
);

  pct_pkg::mode_t chk_mode;

  // track the mode register from the write channel
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_mode <= pct_pkg::MODE_DECODE;
    end else if (cfg.valid && cfg.ready) begin
      chk_mode <= pct_pkg::mode_t'(cfg.mode);
    end
  end

  `PCT_ASSERT_NEXT(a_result_hold, result.valid && !result.ready, result.valid && $stable(result.out_byte) && $stable(result.run_last), "result word changed while stalled")

  `PCT_ASSERT_NOW(a_done_is_last, result.valid && result.string_done, result.run_last, "string end flagged on a byte that is not last of its run")

  `PCT_ASSERT_NOW(a_no_overlap, item.valid && item.ready, !result.valid || (result.ready && result.run_last), "input word taken while a result run is still pending")

  `PCT_ASSERT_NEXT(a_high_escape, item.valid && item.ready && chk_mode != pct_pkg::MODE_DECODE && item.data_byte[7], result.valid && result.out_byte == pct_pkg::PCT_CHAR && !result.run_last, "high byte not escaped in encode mode")

endmodule

bind percent_codec pct_checker u_pct_checker (
  .clk    (clk),
  .rst    (rst),
  .cfg    (cfg),
  .item   (item),
  .result (result)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percent codec testbench
// Drives byte strings through every mode with random gaps on both sides and
// checks each result word against a shadow of the codec held in a class.
// ----------------------------------------------------------------------------

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL     = 150;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_BYTES    = 8;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
  } out_word_t;

  // Shadow of the codec: mode, escape state and the words still owed
  class codec_shadow;
    pct_pkg::mode_t mode;
    esc_t           esc;
    logic [7:0]     held;
    out_word_t      awaited[$];
    out_word_t      step_out[$];
    int             errors;

    function new();
      mode   = pct_pkg::MODE_DECODE;
      esc    = ESC_IDLE;
      held   = '0;
      errors = 0;
    endfunction

    function logic url_safe(logic [7:0] b);
      if (b >= pct_pkg::ASCII_LIMIT) return 1'b0;
      if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
        return 1'b1;
      if (b == "-" || b == "." || b == "_" || b == "~") return 1'b1;
      if ((mode == pct_pkg::MODE_ENC_COMPONENT || mode == pct_pkg::MODE_ENC_URI) &&
          (b == "!" || b == "'" || b == "(" || b == ")" || b == "*"))
        return 1'b1;
      if (mode == pct_pkg::MODE_ENC_URI &&
          (b == "#" || b == "$" || b == "&" || b == "+" || b == "," || b == "/" ||
           b == ":" || b == ";" || b == "=" || b == "?" || b == "@"))
        return 1'b1;
      return 1'b0;
    endfunction

    function logic is_hex(logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function logic [3:0] nibble(logic [7:0] b);
      if (b >= "0" && b <= "9") return 4'(b - "0");
      if (b >= "A" && b <= "F") return 4'(b - "A" + 8'd10);
      return 4'(b - "a" + 8'd10);
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return "0" + {4'd0, n};
      return "A" + {4'd0, n} - 8'd10;
    endfunction

    function void put(logic [7:0] b);
      out_word_t w;
      w.out_byte    = b;
      w.run_last    = 1'b0;
      w.string_done = 1'b0;
      step_out.push_back(w);
    endfunction

    function void decode_plain(logic [7:0] b, logic last);
      if (b == pct_pkg::PCT_CHAR) begin
        if (last) put(pct_pkg::PCT_CHAR);
        else esc = ESC_PCT;
      end else begin
        put(b);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      esc_t      was;
      out_word_t w;
      step_out.delete();
      if (mode != pct_pkg::MODE_DECODE) begin
        // encoding drops any half-read escape
        esc = ESC_IDLE;
        if (url_safe(b)) begin
          put(b);
        end else begin
          put(pct_pkg::PCT_CHAR);
          put(hex_char(b[7:4]));
          put(hex_char(b[3:0]));
        end
      end else begin
        was = esc;
        esc = ESC_IDLE;
        case (was)
          ESC_PCT: begin
            if (last) begin
              put(pct_pkg::PCT_CHAR);
              put(b);
            end else if (is_hex(b)) begin
              held = b;
              esc  = ESC_DIGIT;
            end else begin
              decode_plain(b, last);
            end
          end
          ESC_DIGIT: begin
            if (is_hex(b)) begin
              put({nibble(held), nibble(b)});
            end else begin
              put(held);
              decode_plain(b, last);
            end
          end
          default: decode_plain(b, last);
        endcase
        if (last) esc = ESC_IDLE;
      end
      if (step_out.size() > 0) begin
        w = step_out.pop_back();
        w.run_last    = 1'b1;
        w.string_done = last;
        step_out.push_back(w);
      end
      foreach (step_out[i]) awaited.push_back(step_out[i]);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_word(logic [7:0] b, logic rl, logic sd);
      out_word_t want;
      if (awaited.size() == 0) begin
        report($sformatf("word %02h arrived with nothing owed", b));
      end else begin
        want = awaited.pop_front();
        if (b !== want.out_byte)
          report($sformatf("out_byte %02h, owed %02h", b, want.out_byte));
        if (rl !== want.run_last)
          report($sformatf("run_last %b, owed %b on %02h", rl, want.run_last, b));
        if (sd !== want.string_done)
          report($sformatf("string_done %b, owed %b on %02h", sd, want.string_done, b));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  pct_cfg_if cfg_ch();
  pct_in_if  in_ch();
  pct_out_if res_ch();

  percent_codec DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (in_ch),
    .result (res_ch)
  );

  always #5 clk = ~clk;

  codec_shadow shadow;
  logic [7:0]  line_buf[$];
  logic        gap_free   = 1'b0;
  logic        long_stall = 1'b0;
  int          bytes_in    = 0;
  int          bytes_out   = 0;
  int          mode_writes = 0;
  int          quiet_cycles = 0;

  // Note every handshake in a fixed order at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        shadow.mode = pct_pkg::mode_t'(cfg_ch.mode);
        mode_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        shadow.note_byte(in_ch.data_byte, in_ch.string_end);
        bytes_in++;
      end
      if (res_ch.valid && res_ch.ready) begin
        shadow.check_word(res_ch.out_byte, res_ch.run_last, res_ch.string_done);
        bytes_out++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: random hold before each word, one long hold on request
  initial begin : result_sink
    int hold;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_stall) begin
        hold       = LONG_STALL;
        long_stall = 1'b0;
      end else begin
        hold = gap_free ? 0 : $urandom_range(0, 6);
      end
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = gap_free ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.string_end <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_string();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  // Drop valid, wait for every owed word, then let a pending escape settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (shadow.awaited.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(pct_pkg::mode_t m);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.mode  <= m;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] random_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return "0" + 8'(r);
    if (r < 16) return "a" + 8'(r - 10);
    return "A" + 8'(r - 16);
  endfunction

  function automatic logic [7:0] random_any();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  // Well-formed escapes in decode, with broken escapes, lone percent signs and plain bytes
  function automatic void compose_string(pct_pkg::mode_t m);
    int units;
    int kind;
    line_buf.delete();
    units = $urandom_range(1, 4);
    repeat (units) begin
      kind = $urandom_range(0, 9);
      if (m != pct_pkg::MODE_DECODE) begin
        line_buf.push_back(random_any());
      end else if (kind <= 3) begin
        line_buf.push_back(pct_pkg::PCT_CHAR);
        line_buf.push_back(random_hex());
        line_buf.push_back(random_hex());
      end else if (kind == 4) begin
        line_buf.push_back(pct_pkg::PCT_CHAR);
        line_buf.push_back(random_hex());
        line_buf.push_back(random_any());
      end else if (kind == 5) begin
        line_buf.push_back(pct_pkg::PCT_CHAR);
        line_buf.push_back(random_any());
      end else if (kind <= 8) begin
        line_buf.push_back(random_any());
      end else begin
        line_buf.push_back(pct_pkg::PCT_CHAR);
      end
    end
  endfunction

  initial begin : stimulus
    pct_pkg::mode_t m;
    int             sent;
    shadow = new();
    rst              <= 1'b1;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.mode      <= pct_pkg::MODE_DECODE;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.string_end <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: escapes with lower-case hex, a dropped percent, high and zero bytes,
    // a percent near the string end, then a mode change over a pending escape
    write_mode(pct_pkg::MODE_DECODE);
    line_buf = '{"%", "4", "1", "%", "a", "f", "%", "g", 8'hFF, 8'h00,
                 "%", "4", "z", "%", "5"};
    send_string();
    line_buf = '{"%"};
    send_string();
    send_byte("%", 1'b0);
    send_byte("4", 1'b0);
    write_mode(pct_pkg::MODE_ENC_GENERAL);
    line_buf = '{8'h00, "~", 8'hFF};
    send_string();
    write_mode(pct_pkg::MODE_ENC_COMPONENT);
    line_buf = '{"!", "#"};
    send_string();
    write_mode(pct_pkg::MODE_ENC_URI);
    line_buf = '{"@", " ", "#"};
    send_string();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) m = pct_pkg::MODE_ENC_GENERAL;
      else if ($urandom_range(0, 1) == 0) m = pct_pkg::MODE_DECODE;
      else m = pct_pkg::mode_t'($urandom_range(1, 3));
      write_mode(m);
      gap_free = (p == 2 || p == 5);
      // hold the result side while input keeps coming, so the codec backs up
      if (p == 3) long_stall = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        compose_string(m);
        send_string();
        sent += line_buf.size();
      end
    end

    gap_free = 1'b0;
    drain();
    $display("covered %0d input words, %0d result words, %0d mode writes",
             bytes_in, bytes_out, mode_writes);
    $display("decode escapes, all three encode sets, a long result stall, gap-free runs");
    if (shadow.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
